@@ hdl/mbba_pkg.sv @@
// ----------------------------------------------------------------------------
// mbba_pkg: shared types and constants of the multi-block bump allocator
// Payload structs, status codes, the scan token that runs down the block
// cells and the write bundle that opens a new block.
// ----------------------------------------------------------------------------
package mbba_pkg;

	localparam int MAX_BLOCKS_DEF   = 16;
	localparam int GROWTH_LIMIT_DEF = 33554432;
	localparam int GROWTH_DIV       = 4;
	localparam int GROWTH_SHIFT     = 2;

	localparam int TYPE_W  = 5;
	localparam int SIZE_W  = 40;
	localparam int ALIGN_W = 32;
	localparam int SLOT_W  = 8;   // holds any slot number up to 256 blocks
	localparam int OUTIX_W = 4;

	localparam logic [SIZE_W-1:0] MIN_BLOCK_RESET = 40'd4194304;

	typedef enum logic [1:0] {
		ST_PLACED = 2'd0,
		ST_NEW    = 2'd1,
		ST_BAD    = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_GROW,
		FSM_PLACE
	} fsm_t;

	typedef struct packed {
		logic [TYPE_W-1:0]  memory_type;
		logic [SIZE_W-1:0]  request_size;
		logic [ALIGN_W-1:0] alignment;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [OUTIX_W-1:0]  block_index;
		logic [SIZE_W-1:0]   offset;
		logic [SIZE_W-1:0]   new_block_size;
	} rsp_t;

	// Request token handed from cell to cell, one cell per cycle
	typedef struct packed {
		logic               live;
		logic               found;
		logic               have_free;
		logic [TYPE_W-1:0]  mem_type;
		logic [SIZE_W-1:0]  size;
		logic [ALIGN_W-1:0] mask;       // alignment minus one
		logic [SLOT_W-1:0]  slot;       // slot of the placement
		logic [SLOT_W-1:0]  free_slot;  // lowest free slot seen
		logic [SIZE_W-1:0]  off;
	} tok_t;

	// Opens a new block in one cell
	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  slot;
		logic [TYPE_W-1:0]  mem_type;
		logic [SIZE_W-1:0]  cap;
		logic [SIZE_W-1:0]  next_off;
	} wr_t;

endpackage

@@ hdl/mbba_cell.sv @@
// ----------------------------------------------------------------------------
// mbba_cell: one block slot of the allocator
// Holds one block entry, checks the passing request token against it, bumps
// its offset on a fit and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module mbba_cell #(
	parameter int INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mbba_pkg::tok_t tok_in,
	input  mbba_pkg::wr_t  wr,
	output mbba_pkg::tok_t tok_out
);

	logic                          valid_q;
	logic [mbba_pkg::TYPE_W-1:0]   type_q;
	logic [mbba_pkg::SIZE_W-1:0]   cap_q;
	logic [mbba_pkg::SIZE_W-1:0]   next_q;
	mbba_pkg::tok_t                tok_q;
	mbba_pkg::tok_t                tok_d;

	logic [mbba_pkg::SIZE_W:0]     rnd_sum;
	logic [mbba_pkg::SIZE_W-1:0]   off;
	logic [mbba_pkg::SIZE_W:0]     end_sum;
	logic                          fits;
	logic                          wr_hit;

	localparam logic [mbba_pkg::SLOT_W-1:0] MY_SLOT = mbba_pkg::SLOT_W'(INDEX);

	always_comb begin
		rnd_sum = {1'b0, next_q}
			+ {{(mbba_pkg::SIZE_W + 1 - mbba_pkg::ALIGN_W){1'b0}}, tok_in.mask};
		off     = rnd_sum[mbba_pkg::SIZE_W-1:0]
			& ~{{(mbba_pkg::SIZE_W - mbba_pkg::ALIGN_W){1'b0}}, tok_in.mask};
		end_sum = {1'b0, off} + {1'b0, tok_in.size};
		fits    = tok_in.live && !tok_in.found && valid_q
			&& (type_q == tok_in.mem_type) && !rnd_sum[mbba_pkg::SIZE_W]
			&& (end_sum <= {1'b0, cap_q});
		wr_hit  = wr.en && (wr.slot == MY_SLOT);

		tok_d = tok_in;
		if (fits) begin
			tok_d.found = 1'b1;
			tok_d.slot  = MY_SLOT;
			tok_d.off   = off;
		end
		if (!valid_q && !tok_in.have_free) begin
			tok_d.have_free = 1'b1;
			tok_d.free_slot = MY_SLOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_d;
			if (wr_hit) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			type_q <= wr.mem_type;
			cap_q  <= wr.cap;
			next_q <= wr.next_off;
		end else if (fits) begin
			next_q <= end_sum[mbba_pkg::SIZE_W-1:0];
		end
	end

	assign tok_out = tok_q;

endmodule

@@ hdl/multi_block_bump_allocator.sv @@
// ----------------------------------------------------------------------------
// multi_block_bump_allocator: aligned bump allocation over a table of blocks
// Runs each request down a row of block cells, then either reports the
// placement or sizes, rounds and opens a new block in the lowest free slot, if any.
// ----------------------------------------------------------------------------
//  port group              direction  timing
//  start / busy / req      in         taken at an edge with start high, busy low
//  done / rsp              out        one-cycle strobe, cannot be held off
//  cfg_we / cfg_wdata      in         min_block_size, written at an edge with cfg_we
//
//  A bad alignment reports in the cycle after the transfer.
//  A placement in an existing block reports once the token has passed every
//  cell register of the chain (one cell per cycle) and done is registered;
//  a new block, table full or size overflow adds GROW (sizing), PLACE (rounding).
//  busy is low again in the cycle the result is shown.
//  Reset clears all valid bits and restores min_block_size to 4 MiB.
// ----------------------------------------------------------------------------
module multi_block_bump_allocator #(
	parameter int MAX_BLOCKS   = mbba_pkg::MAX_BLOCKS_DEF,
	parameter int GROWTH_LIMIT = mbba_pkg::GROWTH_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  mbba_pkg::req_t              req,
	input  logic                        cfg_we,
	input  logic [mbba_pkg::SIZE_W-1:0] cfg_wdata,
	output logic                        done,
	output mbba_pkg::rsp_t              rsp
);

	localparam logic [mbba_pkg::SIZE_W-1:0] GROW_MAX = mbba_pkg::SIZE_W'(GROWTH_LIMIT);
	localparam logic [mbba_pkg::SIZE_W-1:0] GROW_QTR =
		mbba_pkg::SIZE_W'(GROWTH_LIMIT / mbba_pkg::GROWTH_DIV);

	mbba_pkg::fsm_t                state_q, state_d;
	logic [mbba_pkg::SIZE_W-1:0]   min_q;
	mbba_pkg::tok_t                chain [MAX_BLOCKS+1];
	mbba_pkg::tok_t                inject;
	mbba_pkg::tok_t                tail;
	mbba_pkg::tok_t                req_q;
	logic                          req_load;
	logic [mbba_pkg::SIZE_W-1:0]   cap_q, cap_d;
	logic [mbba_pkg::SIZE_W:0]     rnd_sum;
	logic [mbba_pkg::SIZE_W-1:0]   rnd_cap;
	logic [mbba_pkg::SIZE_W-1:0]   grown;
	logic                          align_ok;
	logic                          done_q, done_d;
	mbba_pkg::rsp_t                rsp_q, rsp_d;
	mbba_pkg::wr_t                 wr;
	logic [mbba_pkg::SLOT_W+mbba_pkg::OUTIX_W-1:0] slot_ext;
	logic [mbba_pkg::SLOT_W+mbba_pkg::OUTIX_W-1:0] free_ext;

	assign busy = (state_q != mbba_pkg::FSM_IDLE);
	assign tail = chain[MAX_BLOCKS];

	assign align_ok = (req.alignment != '0)
		&& ((req.alignment & (req.alignment - mbba_pkg::ALIGN_W'(1))) == '0);

	always_comb begin
		inject           = '0;
		inject.live      = start && !busy && align_ok;
		inject.mem_type  = req.memory_type;
		inject.size      = req.request_size;
		inject.mask      = req.alignment - mbba_pkg::ALIGN_W'(1);
	end

	assign chain[0] = inject;

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		mbba_cell #(
			.INDEX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[i]),
			.wr     (wr),
			.tok_out(chain[i+1])
		);
	end

	// New block capacity before rounding
	always_comb begin
		grown = req_q.size << mbba_pkg::GROWTH_SHIFT;
		if (req_q.size > GROW_MAX) begin
			cap_d = req_q.size;
		end else if (req_q.size > GROW_QTR) begin
			cap_d = GROW_MAX;
		end else begin
			cap_d = (grown > min_q) ? grown : min_q;
		end
	end

	always_comb begin
		rnd_sum = {1'b0, cap_q}
			+ {{(mbba_pkg::SIZE_W + 1 - mbba_pkg::ALIGN_W){1'b0}}, req_q.mask};
		rnd_cap = rnd_sum[mbba_pkg::SIZE_W-1:0]
			& ~{{(mbba_pkg::SIZE_W - mbba_pkg::ALIGN_W){1'b0}}, req_q.mask};
		slot_ext = {{mbba_pkg::OUTIX_W{1'b0}}, tail.slot};
		free_ext = {{mbba_pkg::OUTIX_W{1'b0}}, req_q.free_slot};
	end

	always_comb begin
		state_d  = state_q;
		done_d   = 1'b0;
		rsp_d    = '0;
		rsp_d.status = mbba_pkg::ST_BAD;
		req_load = 1'b0;
		wr       = '0;
		case (state_q)
			mbba_pkg::FSM_IDLE: begin
				if (start) begin
					if (align_ok) begin
						state_d = mbba_pkg::FSM_SCAN;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			mbba_pkg::FSM_SCAN: begin
				if (tail.live) begin
					if (tail.found) begin
						done_d             = 1'b1;
						rsp_d.status       = mbba_pkg::ST_PLACED;
						rsp_d.block_index  = slot_ext[mbba_pkg::OUTIX_W-1:0];
						rsp_d.offset       = tail.off;
						state_d            = mbba_pkg::FSM_IDLE;
					end else begin
						req_load = 1'b1;
						state_d  = mbba_pkg::FSM_GROW;
					end
				end
			end
			mbba_pkg::FSM_GROW: begin
				state_d = mbba_pkg::FSM_PLACE;
			end
			mbba_pkg::FSM_PLACE: begin
				done_d  = 1'b1;
				state_d = mbba_pkg::FSM_IDLE;
				if (rnd_sum[mbba_pkg::SIZE_W]) begin
					rsp_d.status = mbba_pkg::ST_BAD;
				end else if (!req_q.have_free) begin
					rsp_d.status = mbba_pkg::ST_FULL;
				end else begin
					rsp_d.status         = mbba_pkg::ST_NEW;
					rsp_d.block_index    = free_ext[mbba_pkg::OUTIX_W-1:0];
					rsp_d.new_block_size = rnd_cap;
					wr.en       = 1'b1;
					wr.slot     = req_q.free_slot;
					wr.mem_type = req_q.mem_type;
					wr.cap      = rnd_cap;
					wr.next_off = req_q.size;
				end
			end
			default: begin
				state_d = mbba_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbba_pkg::FSM_IDLE;
			done_q  <= 1'b0;
			min_q   <= mbba_pkg::MIN_BLOCK_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cfg_we) begin
				min_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (req_load) begin
			req_q <= tail;
		end
		if (state_q == mbba_pkg::FSM_GROW) begin
			cap_q <= cap_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.live |-> (state_q == mbba_pkg::FSM_SCAN))
		else $error("token left the cell row outside the scan");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("transfer produced neither a result nor a scan");

	a_open_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == mbba_pkg::FSM_PLACE) && req_q.have_free && done_d)
		else $error("block opened without a free slot or a result");

	a_placed_size: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != mbba_pkg::ST_NEW)) |-> (rsp.new_block_size == '0))
		else $error("new block size shown without a new block");

	a_new_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == mbba_pkg::ST_NEW)) |-> (rsp.offset == '0))
		else $error("new block placement not at offset zero");
`endif

endmodule
